[design/frlh_pkg.sv]
`timescale 1ns / 1ps
// types and constants shared by the frame rate / load histogram
package frlh_pkg;

   localparam int FPS_W       = 10;
   localparam int DIVISOR_W   = 16;
   localparam int TIME_W      = 32;
   localparam int BATCH_W     = 24;
   localparam int BIN_W       = 6;
   localparam int OUT_COUNT_W = 32;
   localparam int CHAN_W      = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam longint USEC_PER_SEC = 1000000;
   localparam int COLOUR_SHIFT     = 9;
   localparam int COLOUR_W         = COLOUR_SHIFT + 1;

   localparam logic [COLOUR_W-1:0] TINT_BASE  = COLOUR_W'(256);
   localparam logic [CHAN_W-1:0]   GREY_EMPTY = CHAN_W'(128);

   localparam logic [FPS_W-1:0]     FPS_MAX_RESET   = FPS_W'(200);
   localparam logic [DIVISOR_W-1:0] BATCH_DIV_RESET = DIVISOR_W'(64);

   localparam logic [CSR_INDEX_W-1:0] CSR_FPS_MAX   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_BATCH_DIV = CSR_INDEX_W'(1);

   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_START,
      ST_DIV,
      ST_ADDR,
      ST_READ,
      ST_UPDATE,
      ST_COLOUR,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                cmd;
      logic [TIME_W-1:0]   elapsed_us;
      logic [BATCH_W-1:0]  batch_count;
      logic [BIN_W-1:0]    read_rate_bin;
      logic [BIN_W-1:0]    read_load_bin;
   } req_type;

   typedef struct packed {
      logic [BIN_W-1:0]       rate_bin;
      logic [BIN_W-1:0]       load_bin;
      logic [OUT_COUNT_W-1:0] cell_count;
      logic [CHAN_W-1:0]      red;
      logic [CHAN_W-1:0]      green;
      logic [CHAN_W-1:0]      blue;
      logic [OUT_COUNT_W-1:0] overall_peak;
   } rsp_type;

endpackage

[design/frlh_div.sv]
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module frlh_div #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DEN_W-1:0] rem_init,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W+1:0] diff;

   always_comb begin
      trial   = {rem_ff, num_ff[NUM_W-1]};
      diff    = {1'b0, trial} - {2'b00, den_ff};
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = rem_init;
         num_in  = num;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DEN_W+1]) begin
            rem_in = diff[DEN_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quot = num_ff;

endmodule

[design/frame_rate_load_histogram.sv]
`timescale 1ns / 1ps
// frame rate / batch load histogram with heat map colour read
// record item: states MUL, START, DIV, ADDR, READ, UPDATE, COLOUR, OUT to result valid;
//   DIV waits for the bin dividers (one bit per cycle), COLOUR for the 10-step divider
// read item: ADDR to OUT; one item in flight, next taken as the result turns valid
// reset: synchronous; then a clearing pass over all RATE_BINS*LOAD_BINS cells
//   sweeps the count memory (and the column peaks) before the first item
module frame_rate_load_histogram #(
   parameter int RATE_BINS  = 64,
   parameter int LOAD_BINS  = 64,
   parameter int COUNT_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  frlh_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output frlh_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [frlh_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [frlh_pkg::CSR_DATA_W-1:0]     csr_data
);

   import frlh_pkg::*;

   localparam int     CELLS        = RATE_BINS * LOAD_BINS;
   localparam int     CELL_W       = $clog2(CELLS);
   localparam int     RB_W         = $clog2(RATE_BINS);
   localparam int     LB_W         = $clog2(LOAD_BINS);
   localparam longint RATE_NUM_VAL = longint'(RATE_BINS) * USEC_PER_SEC;
   localparam int     RATE_NUM_W   = $clog2(RATE_NUM_VAL + 1);
   localparam int     DEN_W        = FPS_W + TIME_W;

   localparam logic [RATE_NUM_W-1:0] RATE_NUM = RATE_NUM_W'(RATE_NUM_VAL);
   localparam logic [RB_W-1:0]       RATE_TOP = RB_W'(RATE_BINS - 1);
   localparam logic [LB_W-1:0]       LOAD_TOP = LB_W'(LOAD_BINS - 1);
   localparam logic [CELL_W-1:0]     CELL_TOP = CELL_W'(CELLS - 1);

   logic [COUNT_BITS-1:0] cell_mem [CELLS];
   logic [COUNT_BITS-1:0] peak_mem [LOAD_BINS];

   state_type              state_ff, state_in;
   logic [FPS_W-1:0]       fps_max_ff;
   logic [DIVISOR_W-1:0]   batch_div_ff;
   req_type                item_ff, item_in;
   logic [DEN_W-1:0]       den_ff, den_in;
   logic [RB_W-1:0]        rate_ff, rate_in;
   logic [LB_W-1:0]        load_ff, load_in;
   logic [CELL_W-1:0]      addr_ff, addr_in;
   logic [CELL_W-1:0]      clr_ff, clr_in;
   logic [COUNT_BITS-1:0]  cell_rd_ff, peak_rd_ff;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [COUNT_BITS-1:0]  peak_total_ff, peak_total_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   bin_start, colour_start;
   logic                   rate_busy, load_busy, colour_busy;
   logic [RATE_NUM_W-1:0]  rate_q;
   logic [BATCH_W-1:0]     load_q;
   logic [COLOUR_W-1:0]    colour_q, colour_v;
   logic [COUNT_BITS-1:0]  new_count, new_peak;
   logic [RB_W-1:0]        rate_sel;
   logic [LB_W-1:0]        load_sel;
   logic                   clearing, record_upd;

   frlh_div #(.NUM_W(RATE_NUM_W), .DEN_W(DEN_W)) u_rate_div (
      .clock    (clock),
      .reset    (reset),
      .start    (bin_start),
      .rem_init ('0),
      .num      (RATE_NUM),
      .den      (den_ff),
      .busy     (rate_busy),
      .quot     (rate_q)
   );

   frlh_div #(.NUM_W(BATCH_W), .DEN_W(DIVISOR_W)) u_load_div (
      .clock    (clock),
      .reset    (reset),
      .start    (bin_start),
      .rem_init ('0),
      .num      (item_ff.batch_count),
      .den      (batch_div_ff),
      .busy     (load_busy),
      .quot     (load_q)
   );

   // count <= column peak, so the quotient fits in COLOUR_W bits
   frlh_div #(.NUM_W(COLOUR_W), .DEN_W(COUNT_BITS)) u_colour_div (
      .clock    (clock),
      .reset    (reset),
      .start    (colour_start),
      .rem_init (new_count >> 1),
      .num      ({new_count[0], {COLOUR_SHIFT{1'b0}}}),
      .den      (new_peak),
      .busy     (colour_busy),
      .quot     (colour_q)
   );

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fps_max_ff   <= FPS_MAX_RESET;
         batch_div_ff <= BATCH_DIV_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FPS_MAX:   fps_max_ff   <= csr_data[FPS_W-1:0];
            CSR_BATCH_DIV: batch_div_ff <= csr_data[DIVISOR_W-1:0];
            default: ;
         endcase
      end
   end

   // bin selection and address
   always_comb begin
      if (item_ff.cmd == CMD_READ) begin
         if (32'(item_ff.read_rate_bin) >= 32'(RATE_BINS)) begin
            rate_sel = RATE_TOP;
         end else begin
            rate_sel = RB_W'(item_ff.read_rate_bin);
         end
         if (32'(item_ff.read_load_bin) >= 32'(LOAD_BINS)) begin
            load_sel = LOAD_TOP;
         end else begin
            load_sel = LB_W'(item_ff.read_load_bin);
         end
      end else begin
         if (rate_q >= RATE_NUM_W'(RATE_BINS)) begin
            rate_sel = RATE_TOP;
         end else begin
            rate_sel = RB_W'(rate_q);
         end
         if (load_q >= BATCH_W'(LOAD_BINS)) begin
            load_sel = LOAD_TOP;
         end else begin
            load_sel = LB_W'(load_q);
         end
      end
   end

   // read-modify-write of the counters
   always_comb begin
      record_upd = (state_ff == ST_UPDATE) && (item_ff.cmd == CMD_RECORD);
      if (item_ff.cmd == CMD_RECORD && cell_rd_ff != '1) begin
         new_count = cell_rd_ff + COUNT_BITS'(1);
      end else begin
         new_count = cell_rd_ff;
      end
      if (new_count > peak_rd_ff) begin
         new_peak = new_count;
      end else begin
         new_peak = peak_rd_ff;
      end
   end

   assign clearing     = (state_ff == ST_CLEAR);
   assign bin_start    = (state_ff == ST_START);
   assign colour_start = (state_ff == ST_UPDATE);

   always_ff @(posedge clock) begin
      if (clearing) begin
         cell_mem[clr_ff] <= '0;
      end else if (record_upd) begin
         cell_mem[addr_ff] <= new_count;
      end
      cell_rd_ff <= cell_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (clearing && 32'(clr_ff) < 32'(LOAD_BINS)) begin
         peak_mem[LB_W'(clr_ff)] <= COUNT_BITS'(1);
      end else if (record_upd && new_count > peak_rd_ff) begin
         peak_mem[load_ff] <= new_count;
      end
      peak_rd_ff <= peak_mem[load_ff];
   end

   // heat map colour
   always_comb begin
      if (colour_q > COLOUR_W'(1)) begin
         colour_v = colour_q - COLOUR_W'(1);
      end else begin
         colour_v = colour_q;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      den_in        = den_ff;
      rate_in       = rate_ff;
      load_in       = load_ff;
      addr_in       = addr_ff;
      clr_in        = clr_ff;
      count_in      = count_ff;
      peak_total_in = peak_total_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      req_ready     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + CELL_W'(1);
            if (clr_ff == CELL_TOP) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in = req_data;
               if (req_data.cmd == CMD_READ) begin
                  state_in = ST_ADDR;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            den_in   = DEN_W'(fps_max_ff) * DEN_W'(item_ff.elapsed_us);
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!rate_busy && !load_busy) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            rate_in  = rate_sel;
            load_in  = load_sel;
            addr_in  = CELL_W'(32'(rate_sel) * LOAD_BINS) + CELL_W'(load_sel);
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            count_in = new_count;
            if (item_ff.cmd == CMD_RECORD && new_count > peak_total_ff) begin
               peak_total_in = new_count;
            end
            state_in = ST_COLOUR;
         end
         ST_COLOUR: begin
            if (!colour_busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.rate_bin     = BIN_W'(rate_ff);
               rsp_in.load_bin     = BIN_W'(load_ff);
               rsp_in.cell_count   = OUT_COUNT_W'(count_ff);
               rsp_in.overall_peak = OUT_COUNT_W'(peak_total_ff);
               if (colour_v >= TINT_BASE) begin
                  rsp_in.red   = colour_v[CHAN_W-1:0];
                  rsp_in.green = '0;
                  rsp_in.blue  = '0;
               end else if (colour_v != '0) begin
                  rsp_in.red   = colour_v[CHAN_W-1:0];
                  rsp_in.green = colour_v[CHAN_W-1:0];
                  rsp_in.blue  = colour_v[CHAN_W-1:0];
               end else begin
                  rsp_in.red   = GREY_EMPTY;
                  rsp_in.green = GREY_EMPTY;
                  rsp_in.blue  = GREY_EMPTY;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         peak_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         peak_total_ff <= peak_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff  <= item_in;
      den_ff   <= den_in;
      rate_ff  <= rate_in;
      load_ff  <= load_in;
      addr_ff  <= addr_in;
      count_ff <= count_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // assertions
   a_idle_units_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!rate_busy && !load_busy && !colour_busy))
      else $error("divider busy while idle");

   a_peak_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> (peak_rd_ff != '0))
      else $error("column peak read as zero");

   a_count_below_peak: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> (cell_rd_ff <= peak_rd_ff))
      else $error("cell count above its column peak");

   a_total_covers_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && item_ff.cmd == CMD_RECORD) |=>
      (peak_total_ff >= count_ff))
      else $error("overall peak below updated count");

   a_colour_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (colour_q <= COLOUR_W'(512)))
      else $error("colour quotient out of range");

endmodule
